>>> rtl/gtq_pkg.sv
package gtq_pkg;

   localparam int ID_W = 10;
   localparam int CLASS_IN_W = 4;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;

   localparam int ID_COUNT = 1024;
   localparam int ID_AW = $clog2(ID_COUNT);
   localparam int CLASS_COUNT = 16;
   localparam int CLASS_W = $clog2(CLASS_COUNT);
   localparam int CLASS_QUEUE_DEPTH = 64;
   localparam int DEPTH_W = $clog2(CLASS_QUEUE_DEPTH);
   localparam int STORE_AW = CLASS_W + DEPTH_W;
   localparam int STORE_DEPTH = 2 ** STORE_AW;

   typedef enum logic [OP_W-1:0] {
      OP_ASSIGN  = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_DEQUEUE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]       operation;
      logic [ID_W-1:0]       member_id;
      logic [CLASS_IN_W-1:0] group_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     dequeued_id;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic               go;
      op_type             op;
      logic [ID_W-1:0]    id;
      logic [CLASS_W-1:0] cls;
   } eng_cmd_type;

   typedef struct packed {
      status_type status;
      logic       hit;
   } eng_rsp_type;

endpackage

>>> rtl/gtq_class_table.sv
module gtq_class_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic                        wr_en,
   input  logic [gtq_pkg::ID_AW-1:0]   addr,
   input  logic [gtq_pkg::CLASS_W-1:0] wdata,
   output logic [gtq_pkg::CLASS_W-1:0] rdata,
   output logic                        busy
);
   import gtq_pkg::*;

   logic [CLASS_W-1:0] mem [ID_COUNT];
   logic [CLASS_W-1:0] rdata_ff;
   logic               clearing_ff, clearing_in;
   logic [ID_AW-1:0]   clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ID_AW'(1);
         if (clr_addr_ff == ID_AW'(ID_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = clearing_ff;

endmodule

>>> rtl/gtq_engine.sv
module gtq_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  gtq_pkg::eng_cmd_type     cmd,
   output gtq_pkg::eng_rsp_type     rsp,
   output logic [gtq_pkg::ID_W-1:0] read_id
);
   import gtq_pkg::*;

   logic [ID_W-1:0]    store [STORE_DEPTH];
   logic [ID_W-1:0]    read_id_ff;
   logic [DEPTH_W-1:0] rptr_ff [CLASS_COUNT];
   logic [DEPTH_W-1:0] wptr_ff [CLASS_COUNT];
   logic [DEPTH_W:0]   fill_ff [CLASS_COUNT];
   logic [CLASS_W-1:0] order_ff [CLASS_COUNT];
   logic [CLASS_W-1:0] ord_rptr_ff, ord_wptr_ff;
   logic [CLASS_W:0]   ord_fill_ff;

   logic [CLASS_W-1:0] sel_cls;
   logic [DEPTH_W:0]   sel_fill;
   logic               push, pop, ord_push, ord_pop;
   status_type         status;

   always_comb begin
      sel_cls  = (cmd.op == OP_ENQUEUE) ? cmd.cls : order_ff[ord_rptr_ff];
      sel_fill = fill_ff[sel_cls];
   end

   always_comb begin
      status   = ST_OK;
      push     = 1'b0;
      pop      = 1'b0;
      ord_push = 1'b0;
      ord_pop  = 1'b0;
      if (cmd.go) begin
         case (cmd.op)
            OP_ENQUEUE: begin
               if (sel_fill == (DEPTH_W+1)'(CLASS_QUEUE_DEPTH)) begin
                  status = ST_FULL;
               end else begin
                  push     = 1'b1;
                  ord_push = (sel_fill == '0) &&
                             (ord_fill_ff < (CLASS_W+1)'(CLASS_COUNT));
               end
            end
            OP_DEQUEUE: begin
               if (ord_fill_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  pop     = (sel_fill != '0);
                  ord_pop = (sel_fill <= (DEPTH_W+1)'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            rptr_ff[i] <= '0;
            wptr_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         ord_rptr_ff <= '0;
         ord_wptr_ff <= '0;
         ord_fill_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff[sel_cls] <= wptr_ff[sel_cls] + DEPTH_W'(1);
            fill_ff[sel_cls] <= sel_fill + (DEPTH_W+1)'(1);
         end else if (pop) begin
            rptr_ff[sel_cls] <= rptr_ff[sel_cls] + DEPTH_W'(1);
            fill_ff[sel_cls] <= sel_fill - (DEPTH_W+1)'(1);
         end
         if (ord_push) begin
            ord_wptr_ff <= ord_wptr_ff + CLASS_W'(1);
            ord_fill_ff <= ord_fill_ff + (CLASS_W+1)'(1);
         end else if (ord_pop) begin
            ord_rptr_ff <= ord_rptr_ff + CLASS_W'(1);
            ord_fill_ff <= ord_fill_ff - (CLASS_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ord_push) begin
         order_ff[ord_wptr_ff] <= sel_cls;
      end
      if (push) begin
         store[{sel_cls, wptr_ff[sel_cls]}] <= cmd.id;
      end
      if (pop) begin
         read_id_ff <= store[{sel_cls, rptr_ff[sel_cls]}];
      end
   end

   assign rsp.status = status;
   assign rsp.hit    = pop;
   assign read_id    = read_id_ff;

endmodule

>>> rtl/grouped_team_queue.sv
// An item and its class lookup are registered in s2; its result is then registered for rsp_data.
// Throughput: one item per cycle unless rsp_ready stalls; class table read and per-class update overlap.
// Reset: synchronous, active high; queues come up empty.
// After reset a pass clears the 1024-entry id-to-class table; req_ready stays low until it ends.
module grouped_team_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gtq_pkg::rsp_type rsp_data
);
   import gtq_pkg::*;

   logic               busy, accept, s2_go;
   logic               s2_valid_ff, s2_valid_in;
   req_type            s2_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff;
   logic               hit_ff;
   logic [CLASS_W-1:0] table_cls;
   logic [ID_W-1:0]    read_id;
   eng_cmd_type        cmd;
   eng_rsp_type        eng_rsp;

   assign s2_go     = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy && (!s2_valid_ff || s2_go);
   assign accept    = req_valid && req_ready;

   gtq_class_table u_table (
      .clock (clock),
      .reset (reset),
      .rd_en (accept && (req_data.operation == OP_ENQUEUE)),
      .wr_en (accept && (req_data.operation == OP_ASSIGN)),
      .addr  (req_data.member_id[ID_AW-1:0]),
      .wdata (req_data.group_id[CLASS_W-1:0]),
      .rdata (table_cls),
      .busy  (busy)
   );

   always_comb begin
      cmd.go  = s2_go;
      cmd.op  = op_type'(s2_item_ff.operation);
      cmd.id  = s2_item_ff.member_id;
      cmd.cls = table_cls;
   end

   gtq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rsp     (eng_rsp),
      .read_id (read_id)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_item_ff <= req_data;
      end
      if (s2_go) begin
         status_ff <= eng_rsp.status;
         hit_ff    <= eng_rsp.hit;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.dequeued_id = hit_ff ? read_id : '0;

endmodule

>>> rtl/gtq_checker.sv
module gtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input gtq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gtq_pkg::rsp_type rsp_data
);
   import gtq_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("result or ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_id_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.dequeued_id == '0)
      else $error("nonzero id with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK) || (rsp_data.status == ST_EMPTY) ||
                    (rsp_data.status == ST_FULL))
      else $error("undefined status code");

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (.*);

>>> verif/tb_grouped_team_queue.sv
`timescale 1ns / 100ps

module tb_grouped_team_queue;
   import gtq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int GAP_PCT = 35;
   localparam int CALM_FIRST = 250;
   localparam int CALM_LAST = 370;
   localparam int ITEM_TARGET = 550;

   typedef struct {
      req_type data;
      bit      hold;
   } planned_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   planned_type planned[$];
   planned_type next_item;
   rsp_type     awaited[$];
   rsp_type     want;
   int          items_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;

   // team queue shadow state
   logic [CLASS_W-1:0] class_of_member [ID_COUNT];
   logic [ID_W-1:0]    line_store [CLASS_COUNT][CLASS_QUEUE_DEPTH];
   int                 line_head [CLASS_COUNT];
   int                 line_tail [CLASS_COUNT];
   int                 line_fill [CLASS_COUNT];
   logic [CLASS_W-1:0] service_order[$];

   logic [ID_W-1:0]    id_pool [24];

   grouped_team_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type serve_request(req_type r);
      rsp_type            res;
      logic [CLASS_W-1:0] c;
      res = '0;
      res.status = ST_OK;
      case (r.operation)
         OP_ASSIGN: begin
            class_of_member[r.member_id] = r.group_id;
         end
         OP_ENQUEUE: begin
            c = class_of_member[r.member_id];
            if (line_fill[c] >= CLASS_QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (line_fill[c] == 0)
                  service_order.push_back(c);
               line_store[c][line_tail[c]] = r.member_id;
               line_tail[c] = (line_tail[c] + 1) % CLASS_QUEUE_DEPTH;
               line_fill[c]++;
            end
         end
         OP_DEQUEUE: begin
            if (service_order.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               c = service_order[0];
               if (line_fill[c] != 0) begin
                  res.dequeued_id = line_store[c][line_head[c]];
                  line_head[c] = (line_head[c] + 1) % CLASS_QUEUE_DEPTH;
                  line_fill[c]--;
               end
               if (line_fill[c] == 0)
                  void'(service_order.pop_front());
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic plan(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                       logic [CLASS_IN_W-1:0] cls, bit hold = 1'b0);
      planned_type p;
      p.data.operation = op;
      p.data.member_id = id;
      p.data.group_id = cls;
      p.hold = hold;
      planned.push_back(p);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 70)
         return id_pool[$urandom_range(23)];
      return ID_W'($urandom_range(ID_COUNT - 1));
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited.push_back(serve_request(req_data));
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (planned.size() != 0 && (!planned[0].hold || awaited.size() == 0) &&
                ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                 $urandom_range(99) >= GAP_PCT)) begin
               next_item = planned.pop_front();
               req_valid <= 1'b1;
               req_data <= next_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $error("unexpected item: dequeued_id %0d status %0d",
                      rsp_data.dequeued_id, rsp_data.status);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               if (rsp_data.dequeued_id !== want.dequeued_id) begin
                  $error("dequeued_id: expected %0d, got %0d",
                         want.dequeued_id, rsp_data.dequeued_id);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
            end
            results_seen++;
         end
         rsp_ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                      ($urandom_range(99) >= GAP_PCT);
      end
   end

   initial begin
      int  kind;
      int  n;
      int  floods;
      bit  hold_next;
      logic [ID_W-1:0] members [16];

      foreach (class_of_member[i])
         class_of_member[i] = '0;
      foreach (line_fill[i]) begin
         line_head[i] = 0;
         line_tail[i] = 0;
         line_fill[i] = 0;
      end
      foreach (id_pool[i])
         id_pool[i] = ID_W'($urandom_range(ID_COUNT - 1));
      id_pool[0] = '0;
      id_pool[1] = '1;

      // directed
      plan(OP_DEQUEUE, 10'd0, 4'd0);
      plan(OP_SPARE, 10'd1023, 4'd15);
      plan(OP_ENQUEUE, 10'd0, 4'd15);
      plan(OP_ASSIGN, 10'd1023, 4'd15);
      plan(OP_ENQUEUE, 10'd1023, 4'd0);
      plan(OP_ASSIGN, 10'd5, 4'd15);
      plan(OP_ENQUEUE, 10'd5, 4'd0);
      plan(OP_ENQUEUE, 10'd682, 4'd5);
      plan(OP_ASSIGN, 10'd341, 4'd10);
      plan(OP_ENQUEUE, 10'd341, 4'd5);
      repeat (6) plan(OP_DEQUEUE, 10'd0, 4'd0);
      plan(OP_ASSIGN, 10'd0, 4'd15);
      plan(OP_ENQUEUE, 10'd0, 4'd0);
      plan(OP_ENQUEUE, 10'd1023, 4'd0);
      plan(OP_SPARE, 10'd0, 4'd0);
      plan(OP_DEQUEUE, 10'd1023, 4'd15);
      plan(OP_DEQUEUE, 10'd0, 4'd0);
      plan(OP_DEQUEUE, 10'd0, 4'd0);

      // random
      floods = 0;
      hold_next = 1'b1;
      while (planned.size() < ITEM_TARGET) begin
         kind = $urandom_range(99);
         if (planned.size() > 350 && floods == 0)
            kind = 85;
         if (kind < 50 || (kind >= 80 && kind < 90 && floods >= 2)) begin
            n = $urandom_range(30, 10);
            repeat (n) begin
               kind = $urandom_range(99);
               if (kind < 25)
                  plan(OP_ASSIGN, pick_id(), CLASS_IN_W'($urandom_range(15)), hold_next);
               else if (kind < 65)
                  plan(OP_ENQUEUE, pick_id(), CLASS_IN_W'($urandom_range(15)), hold_next);
               else if (kind < 95)
                  plan(OP_DEQUEUE, pick_id(), CLASS_IN_W'($urandom_range(15)), hold_next);
               else
                  plan(OP_SPARE, pick_id(), CLASS_IN_W'($urandom_range(15)), hold_next);
               hold_next = 1'b0;
            end
         end else if (kind < 65) begin
            repeat ($urandom_range(20, 8))
               plan(OP_DEQUEUE, ID_W'($urandom_range(1023)), CLASS_IN_W'($urandom_range(15)));
         end else if (kind < 80) begin
            // every class listed in the order queue
            for (int c = 0; c < CLASS_COUNT; c++) begin
               members[c] = ID_W'($urandom_range(ID_COUNT - 1));
               plan(OP_ASSIGN, members[c], CLASS_IN_W'(c));
            end
            for (int c = 0; c < CLASS_COUNT; c++)
               plan(OP_ENQUEUE, members[c], CLASS_IN_W'($urandom_range(15)));
            repeat ($urandom_range(20, 8)) plan(OP_DEQUEUE, 10'd0, 4'd0);
         end else if (kind < 90) begin
            // overfill one class, then drain it
            floods++;
            n = $urandom_range(15);
            for (int k = 0; k < 4; k++) begin
               members[k] = ID_W'($urandom_range(ID_COUNT - 1));
               plan(OP_ASSIGN, members[k], CLASS_IN_W'(n));
            end
            for (int k = 0; k < CLASS_QUEUE_DEPTH + 3; k++)
               plan(OP_ENQUEUE, members[k % 4], CLASS_IN_W'($urandom_range(15)));
            repeat (CLASS_QUEUE_DEPTH + 5) plan(OP_DEQUEUE, 10'd0, 4'd0);
         end else begin
            repeat ($urandom_range(8, 2))
               plan(OP_W'($urandom_range(3)), ID_W'($urandom_range(1023)),
                    CLASS_IN_W'($urandom_range(15)));
         end
      end
      plan(OP_DEQUEUE, 10'd0, 4'd0, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (planned.size() != 0 || req_valid || awaited.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
